// ===== sv/priority_process_scheduler_unit_macros.svh =====
// Assertion macros for the scheduler RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef PRIORITY_PROCESS_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_PROCESS_SCHEDULER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/pps_pkg.sv =====
// Shared types and constants of the priority process scheduler.
// Depends on nothing; imported by every RTL module.
package pps_pkg;
   localparam int SLOTS   = 16;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] proc_id;
      logic [31:0] arrival_time;
      logic [15:0] burst_length;
      logic [7:0]  prio_level;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] tick_time;
      logic        running_valid;
      logic [15:0] running_id;
      logic        done_valid;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic        all_finished;
   } rsp_type;

   // One slot entry as held in the memory.
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic [7:0]  priority_lvl;
   } entry_type;

   // Memory access command from the sequencer.
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
   } mem_cmd_type;
endpackage

// ===== sv/pps_if.sv =====
// Valid/ready channel interface carrying one payload beat.
// Depends on pps_pkg only through the payload type parameter.
interface pps_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pps_slot_ram.sv =====
// Slot entry memory: one write port, one registered read port.
// Depends on pps_pkg for the entry type and the access command.
module pps_slot_ram import pps_pkg::*; (
   input  logic        clock,
   input  mem_cmd_type cmd,
   output entry_type   rd_data
);
   entry_type mem [SLOTS];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data <= mem[cmd.rd_addr];
      end
   end
endmodule

// ===== sv/pps_seq.sv =====
// Sequencer: walks the slot memory for add, remove and tick operations.
// Depends on pps_pkg and the assertion macro header.
`include "priority_process_scheduler_unit_macros.svh"
module pps_seq import pps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        preempt,
   input  logic        req_valid,
   input  req_type     req_data,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output mem_cmd_type cmd,
   input  entry_type   rd_data
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_LAST  = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_WB    = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // Flag vectors held in flip-flops, cleared by reset.
   logic [SLOTS-1:0] valid_ff, valid_in, started_ff, started_in;
   logic [SLOTS-1:0] fin_ff, fin_in, ready_ff, ready_in;
   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;     // address issued
   logic [SLOT_W-1:0] ridx_ff, ridx_in;   // address of data now returning
   logic              rvld_ff, rvld_in;
   logic [31:0]       now_ff, now_in;
   logic              busy_ff, busy_in, pre_ff, pre_in;
   logic [SLOT_W-1:0] run_ff, run_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic              bestv_ff, bestv_in;
   logic [7:0]        bestp_ff, bestp_in, runp_ff, runp_in;
   logic              hit_ff, hit_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              out_ff, out_in;
   entry_type         wb_ent;

   logic [SLOTS-1:0] live;
   logic [SLOT_W-1:0] free_idx;
   logic              free_ok;
   logic              wb_done;

   assign live = valid_ff & ~fin_ff;

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
            free_ok  = 1'b1;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign rsp_valid = out_ff;
   assign rsp_data  = rsp_ff;
   assign wb_done   = (state_ff == S_WB) && rsp_in.done_valid;

   // Main sequencer.
   always_comb begin
      state_in = state_ff; idx_in = idx_ff; ridx_in = idx_ff; rvld_in = 1'b0;
      valid_in = valid_ff; started_in = started_ff; fin_in = fin_ff; ready_in = ready_ff;
      now_in = now_ff; busy_in = busy_ff; run_in = run_ff; pre_in = pre_ff;
      best_in = best_ff; bestv_in = bestv_ff; bestp_in = bestp_ff; runp_in = runp_ff;
      hit_in = hit_ff; req_in = req_ff; rsp_in = rsp_ff; out_in = out_ff;
      wb_ent = rd_data;
      cmd = '0;
      if (out_ff && rsp_ready) begin
         out_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            pre_in = preempt;
            if (req_valid && req_ready) begin
               req_in = req_data;
               rsp_in = '0;
               unique case (req_data.opcode)
                  OP_ADD: begin
                     if (free_ok) begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = free_idx;
                        cmd.wr_data.id = req_data.proc_id;
                        cmd.wr_data.arrival = req_data.arrival_time;
                        cmd.wr_data.burst = (req_data.burst_length == 16'd0) ?
                           16'd1 : req_data.burst_length;
                        cmd.wr_data.remaining = cmd.wr_data.burst;
                        cmd.wr_data.priority_lvl = req_data.prio_level;
                        valid_in[free_idx] = 1'b1;
                        started_in[free_idx] = 1'b0;
                        fin_in[free_idx] = 1'b0;
                        ready_in[free_idx] = 1'b0;
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                     state_in = S_OUT;
                  end
                  OP_TICK: begin
                     if (live == '0) begin
                        rsp_in.status = ST_IGNORED;
                        state_in = S_OUT;
                     end else begin
                        idx_in = '0; bestv_in = 1'b0; hit_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     idx_in = '0; hit_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SCAN, S_LAST: begin
            // Issue a read for idx_ff, consume data for ridx_ff.
            if (state_ff == S_SCAN) begin
               cmd.rd_en = 1'b1; cmd.rd_addr = idx_ff;
               rvld_in = 1'b1;
               idx_in = idx_ff + SLOT_W'(1);
               if (idx_ff == SLOT_W'(SLOTS - 1)) state_in = S_LAST;
            end else begin
               state_in = S_RUN;
            end
            if (rvld_ff) begin
               if (req_ff.opcode == OP_REMOVE) begin
                  if (!hit_ff && valid_ff[ridx_ff] && rd_data.id == req_ff.proc_id) begin
                     hit_in = 1'b1; best_in = ridx_ff;
                  end
               end else begin
                  logic rdy;
                  rdy = ready_ff[ridx_ff];
                  if (valid_ff[ridx_ff] && !started_ff[ridx_ff] && !fin_ff[ridx_ff]
                      && rd_data.arrival == now_ff) begin
                     rdy = 1'b1; ready_in[ridx_ff] = 1'b1;
                  end
                  if (valid_ff[ridx_ff] && rdy &&
                      (!bestv_ff || rd_data.priority_lvl < bestp_ff)) begin
                     bestv_in = 1'b1; best_in = ridx_ff; bestp_in = rd_data.priority_lvl;
                  end
                  if (ridx_ff == run_ff) runp_in = rd_data.priority_lvl;
               end
            end
         end
         S_RUN: begin
            if (req_ff.opcode == OP_REMOVE) begin
               if (hit_ff) begin
                  if (busy_ff && run_ff == best_ff) busy_in = 1'b0;
                  valid_in[best_ff] = 1'b0; ready_in[best_ff] = 1'b0;
                  started_in[best_ff] = 1'b0; fin_in[best_ff] = 1'b0;
               end else begin
                  rsp_in.status = ST_NOTFOUND;
               end
               state_in = S_OUT;
            end else begin
               logic [SLOT_W-1:0] r;
               logic              b;
               r = run_ff; b = busy_ff;
               if (!busy_ff) begin
                  if (bestv_ff) begin
                     ready_in[best_ff] = 1'b0; r = best_ff; b = 1'b1;
                  end
               end else if (pre_ff && bestv_ff && bestp_ff < runp_ff) begin
                  ready_in[run_ff] = 1'b1; ready_in[best_ff] = 1'b0; r = best_ff;
               end
               run_in = r; busy_in = b;
               rsp_in.tick_time = now_ff;
               now_in = now_ff + 32'd1;
               if (b) begin
                  cmd.rd_en = 1'b1; cmd.rd_addr = r;
                  state_in = S_WB;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_WB: begin
            // Read-modify-write of the running entry; now_ff already holds the end of the tick.
            wb_ent.remaining = (rd_data.remaining > 16'd0) ?
               rd_data.remaining - 16'd1 : 16'd0;
            cmd.wr_en = 1'b1; cmd.wr_addr = run_ff; cmd.wr_data = wb_ent;
            started_in[run_ff] = 1'b1;
            rsp_in.running_valid = 1'b1;
            rsp_in.running_id = rd_data.id;
            if (wb_ent.remaining == 16'd0) begin
               rsp_in.done_valid = 1'b1;
               rsp_in.turnaround = now_ff - rd_data.arrival;
               rsp_in.waiting = now_ff - rd_data.arrival - 32'(rd_data.burst);
               fin_in[run_ff] = 1'b1;
               busy_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_in.all_finished = ((valid_ff & ~fin_ff) == '0);
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; started_ff <= '0; fin_ff <= '0;
         ready_ff <= '0; now_ff <= '0; busy_ff <= 1'b0; run_ff <= '0;
         out_ff <= 1'b0; rvld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; started_ff <= started_in;
         fin_ff <= fin_in; ready_ff <= ready_in; now_ff <= now_in;
         busy_ff <= busy_in; run_ff <= run_in; out_ff <= out_in; rvld_ff <= rvld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in; ridx_ff <= ridx_in; pre_ff <= pre_in;
      best_ff <= best_in; bestv_ff <= bestv_in; bestp_ff <= bestp_in;
      runp_ff <= runp_in; hit_ff <= hit_in; req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   `PPS_ASSERT_IMP(a_busy_valid, clock, reset, busy_ff, live[run_ff], "running slot not live")
   `PPS_ASSERT_IMP(a_no_accept_out, clock, reset, out_ff, state_ff == S_IDLE, "beat off idle")
   `PPS_ASSERT_NEXT(a_done_idle, clock, reset, wb_done, !busy_ff, "completed slot still busy")
   `PPS_ASSERT_IMP(a_wb_busy, clock, reset, state_ff == S_WB, busy_ff, "write-back while idle")
endmodule

// ===== sv/priority_process_scheduler_unit.sv =====
// Priority process scheduler: add, remove and tick over a 16-slot table.
// Add and ignored tick go straight to the result beat; remove and tick first scan every slot,
// and a tick that runs a process writes its entry back. Throughput: one item at a time, the next
// request taken after the result beat; the slot scan, one memory read per cycle, sets the rate.
// Reset (synchronous): all slots empty, time zero, CPU idle, non-preemptive mode.
// Depends on pps_pkg, pps_if, pps_slot_ram and pps_seq.
module priority_process_scheduler_unit import pps_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   pps_if.sink   req_ch,
   pps_if.source rsp_ch,
   input  logic  csr_wr_en,
   input  logic  csr_wr_data
);
   logic        preempt_ff;
   mem_cmd_type cmd;
   entry_type   rd_data;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         preempt_ff <= 1'b0;
      end else if (csr_wr_en) begin
         preempt_ff <= csr_wr_data;
      end
   end

   pps_slot_ram u_ram (.clock(clock), .cmd(cmd), .rd_data(rd_data));

   pps_seq u_seq (
      .clock(clock), .reset(reset), .preempt(preempt_ff),
      .req_valid(req_ch.valid), .req_data(req_ch.data), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .cmd(cmd), .rd_data(rd_data)
   );
endmodule
